/* rtl/segy_pkg.sv */
// Package for the sample-to-float converter: field widths, format codes,
// register indexes, rounding function. No dependencies.
package segy_pkg;

	localparam int SampleW = 32;
	localparam int WexpW   = 16;
	localparam int FmtW    = 4;
	localparam int CfgIdxW = 1;
	localparam int CfgDatW = 4;

	localparam logic [FmtW-1:0] FMT_IBM   = 4'd1;
	localparam logic [FmtW-1:0] FMT_INT32 = 4'd2;
	localparam logic [FmtW-1:0] FMT_INT16 = 4'd3;
	localparam logic [FmtW-1:0] FMT_RAW   = 4'd4;
	localparam logic [FmtW-1:0] FMT_IEEE  = 4'd5;
	localparam logic [FmtW-1:0] FMT_INT8A = 4'd6;
	localparam logic [FmtW-1:0] FMT_INT8B = 4'd8;

	localparam logic [CfgIdxW-1:0] REG_FORMAT = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_SWAP   = 1'd1;

	// Intermediate: sign, magnitude and exponent so that value = mag * 2^exp.
	typedef struct packed {
		logic        zero_out;
		logic        pass;
		logic [31:0] pass_bits;
		logic        sign;
		logic [31:0] mag;
		logic signed [18:0] exp;
	} unpk_t;

	// Round sign, m * 2^e to single precision, nearest even.
	function automatic logic [31:0] pack_float(input logic sign, input logic [31:0] m,
			input logic signed [18:0] e);
		logic [5:0]         p;
		logic signed [19:0] shift;
		logic signed [19:0] lim;
		logic [55:0]        ext;
		logic [31:0]        q;
		logic               g;
		logic               st;
		logic signed [19:0] ef;
		p = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (m[i]) p = 6'(i);
		end
		shift = 20'(p) - 20'sd23;
		lim = -20'sd149 - 20'(e);
		if (lim > shift) shift = lim;
		q = 32'd0;
		g = 1'b0;
		st = 1'b0;
		if (shift <= 0) begin
			q = m << 5'(-shift);
		end else if (shift > 33) begin
			q = 32'd0;
		end else begin
			ext = {m, 24'd0} >> 6'(shift);
			q = ext[55:24];
			g = ext[23];
			st = |ext[22:0];
			if (g && (st || q[0])) q = q + 32'd1;
		end
		ef = 20'(e) + shift + 20'sd150;
		if (q[24]) begin
			q = q >> 1;
			ef = ef + 20'sd1;
		end
		if (m == 32'd0) return {sign, 31'd0};
		if (!q[23]) return {sign, 8'd0, q[22:0]};
		if (ef >= 20'sd255) return {sign, 8'hFF, 23'd0};
		return {sign, ef[7:0], q[22:0]};
	endfunction

endpackage

/* rtl/segy_sample_to_float.sv */
// Top level of the sample-to-float converter: decode stage and weighting
// stage. Depends on segy_pkg.
//
// Converts one SEG-Y sample word per beat into IEEE single precision. Two
// register stages: stage 1 decodes the selected format (IBM float, signed
// int32/16/8, raw or IEEE bits, optional byte swap) into sign/magnitude/
// exponent and rounds once; stage 2 scales by 2^-weight_exponent and rounds
// again only when the exponent is nonzero. One beat per cycle while
// m_tready is high; each stage loads whenever it is empty or being
// drained. Config (index 0 format, 1 byte swap) goes over cfg_valid/
// cfg_ready (always high); users must write it only while idle, unchecked.
module segy_sample_to_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] raw_sample, [47:32] weight_exponent
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sample_float
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [segy_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [segy_pkg::CfgDatW-1:0] cfg_data
);

	logic [segy_pkg::FmtW-1:0] fmt_q;
	logic                      swap_q;
	logic                      v_s1, v_s2;
	logic [31:0]               f_s1;
	logic signed [15:0]        w_s1;
	logic [31:0]               res_s2;
	logic                      adv1, adv2;
	logic [31:0]               raw, w32, dec, wres;
	logic [15:0]               w16;
	logic [31:0]               mag;
	logic                      sg;

	assign cfg_ready = 1'b1;
	assign adv2 = !v_s2 || m_tready;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;
	assign m_tvalid = v_s2;
	assign m_tdata = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= segy_pkg::FMT_IBM;
			swap_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				segy_pkg::REG_FORMAT: fmt_q <= cfg_data;
				segy_pkg::REG_SWAP:   swap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Decode.
	always_comb begin
		raw = s_tdata[31:0];
		w32 = swap_q ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
		w16 = swap_q ? {raw[7:0], raw[15:8]} : raw[15:0];
		dec = 32'd0;
		sg  = 1'b0;
		mag = 32'd0;
		unique case (fmt_q)
			segy_pkg::FMT_IBM:
				dec = segy_pkg::pack_float(w32[31], {8'd0, w32[23:0]},
					19'(signed'({1'b0, w32[30:24]})) * 19'sd4 - 19'sd280);
			segy_pkg::FMT_INT32: begin
				sg  = w32[31];
				mag = sg ? (~w32 + 32'd1) : w32;
				dec = segy_pkg::pack_float(sg, mag, 19'sd0);
			end
			segy_pkg::FMT_INT16: begin
				sg  = w16[15];
				mag = sg ? (32'(~w16) + 32'd1) & 32'hFFFF : 32'(w16);
				dec = segy_pkg::pack_float(sg, mag, 19'sd0);
			end
			segy_pkg::FMT_RAW:  dec = raw;
			segy_pkg::FMT_IEEE: dec = w32;
			segy_pkg::FMT_INT8A, segy_pkg::FMT_INT8B: begin
				sg  = raw[7];
				mag = sg ? (32'(~raw[7:0]) + 32'd1) & 32'hFF : 32'(raw[7:0]);
				dec = segy_pkg::pack_float(sg, mag, 19'sd0);
			end
			default: dec = 32'd0;
		endcase
	end

	// Weighting.
	always_comb begin
		if (w_s1 == 16'sd0) begin
			wres = f_s1;
		end else if (f_s1[30:23] == 8'hFF) begin
			wres = (f_s1[22:0] != 23'd0) ? (f_s1 | 32'h0040_0000) : f_s1;
		end else if (f_s1[30:0] == 31'd0) begin
			wres = f_s1;
		end else if (f_s1[30:23] == 8'd0) begin
			wres = segy_pkg::pack_float(f_s1[31], {9'd0, f_s1[22:0]},
				-19'sd149 - 19'(w_s1));
		end else begin
			wres = segy_pkg::pack_float(f_s1[31], {8'd0, 1'b1, f_s1[22:0]},
				19'(signed'({1'b0, f_s1[30:23]})) - 19'sd150 - 19'(w_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			f_s1 <= dec;
			w_s1 <= s_tdata[47:32];
		end
		if (adv2 && v_s1) res_s2 <= wres;
	end

`ifndef ASSERT_OFF
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted beat lost in stage 1");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !m_tready) |=> (v_s2 && $stable(res_s2)))
		else $error("stalled result changed");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while full");
`endif

endmodule
